/* sv/stbs_pkg.sv */
`default_nettype none

package stbs_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths of the words on the ports.
    localparam int ACTION_W = 2;
    localparam int IN_KEY_W = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 10;
    localparam int ENTRY_W  = 11;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [IN_KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [ENTRY_W-1:0]  entries;
    } t_out_word;

endpackage

`default_nettype wire

/* sv/sorted_table_binary_search.sv */
`default_nettype none

// Channel   Direction  Handshake               Word
// in        input      i_in_valid / o_in_stall action, key
// out       output     o_out_valid / i_out_stall status, position, entries
// cfg       input      i_cfg_valid / o_cfg_ready signed_compare
//
// Append, clear and unused actions give their result in the cycle after the word is taken.
// A search runs one probe after another, each probe being one key memory read plus one
// compare; a match ends it early.
// Reset clears the fill count and the compare mode; the key memory keeps its contents.
// The input stalls while a search runs and while an unread result is stalled downstream.
module sorted_table_binary_search (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire stbs_pkg::t_in_word   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output stbs_pkg::t_out_word       o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state r_state, n_state;

    logic [stbs_pkg::KEY_WIDTH-1:0] r_mem [stbs_pkg::TABLE_DEPTH];
    logic [stbs_pkg::KEY_WIDTH-1:0] r_rdata;
    logic [stbs_pkg::KEY_WIDTH-1:0] r_key, n_key;
    logic [stbs_pkg::CNT_W-1:0]     r_fill, n_fill;
    logic [stbs_pkg::CNT_W-1:0]     r_lo, n_lo;
    logic [stbs_pkg::CNT_W-1:0]     r_hi, n_hi;
    logic [stbs_pkg::ADDR_W-1:0]    r_mid, n_mid;
    logic                           r_signed;
    logic                           r_out_valid, n_out_valid;
    stbs_pkg::t_out_word            r_out, n_out;

    logic                           in_take;
    logic                           wr_en;
    logic [stbs_pkg::ADDR_W-1:0]    rd_addr;
    logic [stbs_pkg::KEY_WIDTH-1:0] cmp_a, cmp_b;
    logic                           cmp_eq, cmp_lt;
    logic [stbs_pkg::CNT_W-1:0]     step_lo, step_hi, span, fill_half;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Shared comparator: flipping the sign bits turns a signed compare into an unsigned one.
    always_comb begin
        cmp_a = r_rdata;
        cmp_b = r_key;
        if (r_signed) begin
            cmp_a[stbs_pkg::KEY_WIDTH-1] = ~r_rdata[stbs_pkg::KEY_WIDTH-1];
            cmp_b[stbs_pkg::KEY_WIDTH-1] = ~r_key[stbs_pkg::KEY_WIDTH-1];
        end
        cmp_eq = (cmp_a == cmp_b);
        cmp_lt = (cmp_a < cmp_b);
    end

    // Narrowed range after the current probe, its span for the next midpoint, and half the fill.
    always_comb begin
        if (cmp_lt) begin
            step_lo = {{(stbs_pkg::CNT_W-stbs_pkg::ADDR_W){1'b0}}, r_mid} + 1'b1;
            step_hi = r_hi;
        end else begin
            step_lo = r_lo;
            step_hi = {{(stbs_pkg::CNT_W-stbs_pkg::ADDR_W){1'b0}}, r_mid};
        end
        span      = step_hi - step_lo;
        fill_half = r_fill >> 1;
    end

    // Sequencer: takes words, runs the probe loop and loads the result register.
    always_comb begin
        logic [stbs_pkg::CNT_W-1:0] next_mid;
        next_mid    = step_lo + (span >> 1);
        n_state     = r_state;
        n_key       = r_key;
        n_fill      = r_fill;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        wr_en       = 1'b0;
        rd_addr     = r_mid;

        unique case (r_state)
            S_IDLE: begin
                rd_addr = fill_half[stbs_pkg::ADDR_W-1:0];
                if (in_take) begin
                    n_key          = i_in.key[stbs_pkg::KEY_WIDTH-1:0];
                    n_out.status   = stbs_pkg::ST_OK;
                    n_out.position = '0;
                    n_out.entries  = stbs_pkg::ENTRY_W'(r_fill);
                    case (i_in.action)
                        stbs_pkg::ACT_APPEND: begin
                            n_out_valid = 1'b1;
                            if (r_fill >= stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH)) begin
                                n_out.status = stbs_pkg::ST_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                n_fill         = r_fill + 1'b1;
                                n_out.position = stbs_pkg::POS_W'(r_fill);
                                n_out.entries  = stbs_pkg::ENTRY_W'(r_fill + 1'b1);
                            end
                        end
                        stbs_pkg::ACT_SEARCH: begin
                            if (r_fill == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = stbs_pkg::ST_MISS;
                            end else begin
                                n_lo    = '0;
                                n_hi    = r_fill;
                                n_mid   = fill_half[stbs_pkg::ADDR_W-1:0];
                                n_state = S_SEARCH;
                            end
                        end
                        stbs_pkg::ACT_CLEAR: begin
                            n_out_valid   = 1'b1;
                            n_fill        = '0;
                            n_out.entries = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // The entry at r_mid is in r_rdata this cycle.
                n_out.entries = stbs_pkg::ENTRY_W'(r_fill);
                rd_addr       = next_mid[stbs_pkg::ADDR_W-1:0];
                if (cmp_eq) begin
                    n_out_valid    = 1'b1;
                    n_out.status   = stbs_pkg::ST_OK;
                    n_out.position = stbs_pkg::POS_W'(r_mid);
                    n_state        = S_IDLE;
                end else if (step_lo < step_hi) begin
                    n_lo  = step_lo;
                    n_hi  = step_hi;
                    n_mid = next_mid[stbs_pkg::ADDR_W-1:0];
                end else begin
                    n_out_valid    = 1'b1;
                    n_out.status   = stbs_pkg::ST_MISS;
                    n_out.position = '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Key memory: one write port for appends, one registered read port for probes.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[stbs_pkg::ADDR_W-1:0]] <= i_in.key[stbs_pkg::KEY_WIDTH-1:0];
        end
        r_rdata <= r_mem[rd_addr];
    end

    // State, control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_signed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_signed <= i_cfg_data;
            end
        end
        r_key <= n_key;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

/* bench/sorted_table_binary_search_test.sv */
module sorted_table_binary_search_test;

    // The action code that the block answers without touching the table.
    localparam logic [stbs_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int LONG_HOLD    = 300;
    localparam int LIMIT_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Inputs of the block, all known from time zero.
    logic                in_valid  = 1'b0;
    stbs_pkg::t_in_word  in_word   = '0;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_data  = 1'b0;

    logic                o_in_stall;
    logic                o_out_valid;
    stbs_pkg::t_out_word o_out;
    logic                o_cfg_ready;

    // Words waiting to be offered and answers waiting to come back.
    stbs_pkg::t_in_word  pending_words[$];
    stbs_pkg::t_out_word expected_answers[$];

    // Idle rates of the two sides, in percent, and the long receiver hold requests.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int errors      = 0;
    int cycle_count = 0;

    // Own copy of the table, its fill level and the compare mode.
    logic [stbs_pkg::KEY_WIDTH-1:0] key_table [stbs_pkg::TABLE_DEPTH];
    logic [stbs_pkg::CNT_W-1:0]     fill_level  = '0;
    logic                           signed_mode = 1'b0;

    sorted_table_binary_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // True when the stored key orders strictly below the probe key.
    function automatic logic key_below(input logic [stbs_pkg::KEY_WIDTH-1:0] a,
                                       input logic [stbs_pkg::KEY_WIDTH-1:0] b);
        if (signed_mode) begin
            return $signed(a) < $signed(b);
        end
        return a < b;
    endfunction

    // Applies one word to the table copy and returns the answer it must give.
    function automatic stbs_pkg::t_out_word table_answer(input stbs_pkg::t_in_word w);
        stbs_pkg::t_out_word            r;
        logic [stbs_pkg::KEY_WIDTH-1:0] k;
        logic [stbs_pkg::CNT_W-1:0]     lo, hi, mid;
        logic                           found;
        r = '0;
        r.status = stbs_pkg::ST_OK;
        k = w.key[stbs_pkg::KEY_WIDTH-1:0];
        case (w.action)
            stbs_pkg::ACT_APPEND: begin
                if (fill_level >= stbs_pkg::TABLE_DEPTH) begin
                    r.status = stbs_pkg::ST_FULL;
                end else begin
                    key_table[fill_level[stbs_pkg::ADDR_W-1:0]] = k;
                    r.position = fill_level[stbs_pkg::POS_W-1:0];
                    fill_level = fill_level + 1'b1;
                end
            end
            stbs_pkg::ACT_SEARCH: begin
                // Half-open search; the probe order matters even for unsorted tables.
                r.status = stbs_pkg::ST_MISS;
                lo = '0;
                hi = fill_level;
                found = 1'b0;
                while (lo < hi && !found) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (key_table[mid[stbs_pkg::ADDR_W-1:0]] == k) begin
                        found = 1'b1;
                        r.status = stbs_pkg::ST_OK;
                        r.position = mid[stbs_pkg::POS_W-1:0];
                    end else if (key_below(key_table[mid[stbs_pkg::ADDR_W-1:0]], k)) begin
                        lo = mid + 1'b1;
                    end else begin
                        hi = mid;
                    end
                end
            end
            stbs_pkg::ACT_CLEAR: begin
                fill_level = '0;
            end
            default: begin
            end
        endcase
        r.entries = fill_level;
        return r;
    endfunction

    // Driver: offers pending words, holds a stalled word, predicts each accepted one.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) begin
                expected_answers.push_back(table_answer(in_word));
            end
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or a long counted hold when one is asked for.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            out_stall    <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: each accepted result word is checked against the oldest answer.
    always @(posedge clk) begin
        stbs_pkg::t_out_word want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_answers.size() == 0) begin
                $error("result word with no answer waiting: %h", o_out);
                errors++;
            end else begin
                want = expected_answers.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    errors++;
                end
                if (o_out.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_out.position);
                    errors++;
                end
                if (o_out.entries !== want.entries) begin
                    $error("entries: expected %0d, got %0d", want.entries, o_out.entries);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic put_word(input logic [stbs_pkg::ACTION_W-1:0] act,
                            input logic [stbs_pkg::IN_KEY_W-1:0] k);
        stbs_pkg::t_in_word w;
        w.action = act;
        w.key = k;
        pending_words.push_back(w);
    endtask

    // Waits until every word is taken and every answer has come back. The check looks
    // between edges, where the queues and the handshake have settled.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0);
        @(posedge clk);
    endtask

    // Writes the compare mode; only called with the block idle.
    task automatic write_mode(input logic mode);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        do @(posedge clk);
        while (!o_cfg_ready);
        cfg_valid   <= 1'b0;
        signed_mode = mode;
    endtask

    // Mostly runs of clear, sorted appends and searches; some unsorted runs and noise.
    task automatic queue_random_words(input int word_goal, input logic by_sign);
        logic [stbs_pkg::KEY_WIDTH-1:0] run_keys[$];
        logic [stbs_pkg::KEY_WIDTH-1:0] k;
        logic [63:0]                    off, step_max, step;
        int                             n, m, j, added, kind, sel;
        added = 0;
        while (added < word_goal) begin
            kind = $urandom_range(99);
            run_keys.delete();
            if (kind < 90) begin
                put_word(stbs_pkg::ACT_CLEAR, $urandom);
                added++;
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 20);
                off = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom);
                step_max = ($urandom_range(1) == 0) ? 64'd3 : (64'hFFFF_FFFF - off) / (n + 1);
                // Keys rise in the offset domain, which is ascending in the chosen mode.
                for (j = 0; j < n; j++) begin
                    step = 64'($urandom_range(32'(step_max)));
                    if (off + step <= 64'hFFFF_FFFF) begin
                        off = off + step;
                    end
                    run_keys.push_back(off[31:0] ^ {by_sign, 31'b0});
                end
                // A broken run: a few keys out of order.
                if (kind >= 75 && n > 1) begin
                    for (j = 0; j < 3; j++) begin
                        run_keys[$urandom_range(n - 1)] = $urandom;
                    end
                end
                for (j = 0; j < n; j++) begin
                    put_word(stbs_pkg::ACT_APPEND, run_keys[j]);
                end
                added += n;
                m = $urandom_range(1, n + 4);
                for (j = 0; j < m; j++) begin
                    sel = $urandom_range(7);
                    if (n == 0 || sel == 6) begin
                        k = $urandom;
                    end else if (sel == 7) begin
                        case ($urandom_range(3))
                            0: k = '0;
                            1: k = '1;
                            2: k = 32'h7FFF_FFFF;
                            default: k = 32'h8000_0000;
                        endcase
                    end else begin
                        k = run_keys[$urandom_range(n - 1)];
                        if (sel == 4) k = k + 1'b1;
                        if (sel == 5) k = k - 1'b1;
                    end
                    put_word(stbs_pkg::ACT_SEARCH, k);
                end
                added += m;
            end else begin
                for (j = 0; j < 8; j++) begin
                    put_word(stbs_pkg::ACTION_W'($urandom_range(3)), $urandom);
                end
                added += 8;
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        logic [stbs_pkg::KEY_WIDTH-1:0] full_keys[$];
        int                             i;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unsigned mode: empty table, extreme keys, misses, the unused action, clear.
        put_word(stbs_pkg::ACT_SEARCH, 32'd5);
        put_word(stbs_pkg::ACT_APPEND, 32'h0000_0000);
        put_word(stbs_pkg::ACT_APPEND, 32'h0000_0001);
        put_word(stbs_pkg::ACT_APPEND, 32'h7FFF_FFFF);
        put_word(stbs_pkg::ACT_APPEND, 32'h8000_0000);
        put_word(stbs_pkg::ACT_APPEND, 32'hFFFF_FFFF);
        put_word(stbs_pkg::ACT_SEARCH, 32'h0000_0000);
        put_word(stbs_pkg::ACT_SEARCH, 32'hFFFF_FFFF);
        put_word(stbs_pkg::ACT_SEARCH, 32'h8000_0000);
        put_word(stbs_pkg::ACT_SEARCH, 32'h0000_0002);
        put_word(ACT_UNUSED, 32'h0000_007B);
        put_word(stbs_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
        put_word(stbs_pkg::ACT_SEARCH, 32'h0000_0000);
        wait_drained();

        // Signed mode: negative keys sort first; then an unsorted tail.
        write_mode(1'b1);
        put_word(stbs_pkg::ACT_APPEND, 32'h8000_0000);
        put_word(stbs_pkg::ACT_APPEND, 32'hFFFF_FFFF);
        put_word(stbs_pkg::ACT_APPEND, 32'h0000_0000);
        put_word(stbs_pkg::ACT_APPEND, 32'h7FFF_FFFF);
        put_word(stbs_pkg::ACT_SEARCH, 32'h8000_0000);
        put_word(stbs_pkg::ACT_SEARCH, 32'h7FFF_FFFF);
        put_word(stbs_pkg::ACT_SEARCH, 32'hFFFF_FFFF);
        put_word(stbs_pkg::ACT_SEARCH, 32'h0000_0001);
        put_word(stbs_pkg::ACT_APPEND, 32'h0000_0003);
        put_word(stbs_pkg::ACT_SEARCH, 32'h0000_0003);
        put_word(stbs_pkg::ACT_CLEAR, 32'h0000_0000);

        // Fill the table to the top, overflow it, and search it while the receiver holds off.
        for (i = 0; i < stbs_pkg::TABLE_DEPTH; i++) begin
            full_keys.push_back((32'(i) * 32'h0040_0000 + $urandom_range(3)) ^ 32'h8000_0000);
            put_word(stbs_pkg::ACT_APPEND, full_keys[i]);
        end
        holds_asked <= holds_asked + 1;
        put_word(stbs_pkg::ACT_APPEND, $urandom);
        put_word(stbs_pkg::ACT_SEARCH, full_keys[0]);
        put_word(stbs_pkg::ACT_SEARCH, full_keys[stbs_pkg::TABLE_DEPTH - 1]);
        put_word(stbs_pkg::ACT_SEARCH, full_keys[stbs_pkg::TABLE_DEPTH / 2]);
        for (i = 0; i < 10; i++) begin
            put_word(stbs_pkg::ACT_SEARCH,
                     full_keys[$urandom_range(stbs_pkg::TABLE_DEPTH - 1)]);
            put_word(stbs_pkg::ACT_SEARCH, $urandom);
        end
        put_word(stbs_pkg::ACT_CLEAR, $urandom);
        wait_drained();

        // Random phases with alternating compare mode and different idle rates.
        write_mode(1'b0);
        queue_random_words(40, 1'b0);
        wait_drained();

        write_mode(1'b1);
        send_idle_pct <= 57;
        queue_random_words(20, 1'b1);
        // Sender pauses here until every answer is back.
        wait_drained();
        queue_random_words(20, 1'b1);
        wait_drained();

        write_mode(1'b0);
        send_idle_pct <= 0;
        stall_pct     <= 57;
        queue_random_words(40, 1'b0);
        wait_drained();

        write_mode(1'b1);
        send_idle_pct <= 16;
        stall_pct     <= 16;
        queue_random_words(40, 1'b1);
        wait_drained();

        // Room for any stray result word to show up.
        repeat (40) @(posedge clk);
        if (expected_answers.size() != 0) begin
            $error("%0d answers never arrived", expected_answers.size());
            errors++;
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
